[rtl/sha256_message_hasher_defines.svh]
// Assertion macros used by the hasher controller.
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define SHA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/sha_pkg.sv]
// Package: SHA-256 constants, command and status types.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Byte-write source for the block store.
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic      byte_we;
        byte_src_t byte_src;
        logic      fill_inc;
        logic      fill_clr;
        logic      len_add;
        logic      len_clr;
        logic      comp_start;
        logic      round_en;
        logic      chain_add;
        logic      chain_init;
    } sha_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round;
    } sha_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

[rtl/sha256_message_hasher.sv]
// Top level: SHA-256 byte-stream hasher.
//  channel | direction | fields
//  s_      | in        | data_byte, has_byte, end_of_message
//  m_      | out       | digest_word, word_index, last_word
// A byte item is stored in the block; a 64th byte also starts the 64-round compression.
// End of message pads one byte a cycle, pausing for each compression, and compresses once or twice,
// then presents eight words, one per cycle while m_ready is high.
// aresetn is synchronous; it restores the initial hash, length and fill count.
// m_ready low holds the current word; no input is taken until the digest is out.
`timescale 1ns / 1ps
`default_nettype none
module sha256_message_hasher (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_data_byte,
    input  wire         s_has_byte,
    input  wire         s_end_of_message,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha_pkg::*;

    sha_cmd_t  cmd;
    sha_stat_t stat;

    sha_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_has_byte(s_has_byte), .s_end_of_message(s_end_of_message),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_word_index(m_word_index), .m_last_word(m_last_word),
        .stat(stat), .cmd(cmd)
    );

    sha_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .data_byte(s_data_byte),
        .out_sel(m_word_index), .stat(stat), .out_word(m_digest_word)
    );

endmodule
`default_nettype wire

[rtl/sha_datapath.sv]
// Datapath: message window, round logic, chaining words and length.
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  sha_pkg::sha_cmd_t   cmd,
    input  wire  [7:0]          data_byte,
    input  wire  [2:0]          out_sel,
    output sha_pkg::sha_stat_t  stat,
    output logic [31:0]         out_word
);
    import sha_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [63:0] len_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  round_reg;

    logic [7:0]  byte_val;
    logic [2:0]  len_sel;
    logic [31:0] s0, s1, w_new, w_cur, big0, big1, ch, maj, t1, t2;

    // Select the byte that goes into the store.
    always_comb begin
        len_sel = fill_reg[2:0];
        unique case (cmd.byte_src)
            SRC_DATA: byte_val = data_byte;
            SRC_PAD:  byte_val = PAD_BYTE;
            SRC_ZERO: byte_val = 8'h00;
            SRC_LEN:  byte_val = len_reg[8 * (7 - len_sel) +: 8];
            default:  byte_val = 8'h00;
        endcase
    end

    // Schedule word and round function.
    always_comb begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = (round_reg < 6'd16) ? w_reg[0] : w_new;
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big1 + ch + ROUND_K[round_reg] + w_cur;
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big0 + maj;
    end

    // Gather bytes big-endian into the window; the window shifts one word each round.
    always_ff @(posedge aclk) begin
        if (cmd.byte_we) begin
            w_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= byte_val;
        end
        if (cmd.comp_start) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_cur;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // Control counters, length and chaining words.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            round_reg <= '0;
            len_reg   <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
        end else begin
            if (cmd.fill_clr) fill_reg <= '0;
            else if (cmd.fill_inc) fill_reg <= fill_reg + 6'd1;
            if (cmd.len_clr) len_reg <= '0;
            else if (cmd.len_add) len_reg <= len_reg + 64'd8;
            if (cmd.comp_start) round_reg <= '0;
            else if (cmd.round_en) round_reg <= round_reg + 6'd1;
            if (cmd.chain_init) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
            end else if (cmd.chain_add) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign stat.fill  = fill_reg;
    assign stat.round = round_reg;
    assign out_word   = h_reg[out_sel];

endmodule
`default_nettype wire

[rtl/sha_ctrl.sv]
// Controller: sequences byte intake, padding, compression and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire                 s_has_byte,
    input  wire                 s_end_of_message,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [2:0]          m_word_index,
    output logic                m_last_word,
    input  sha_pkg::sha_stat_t  stat,
    output sha_pkg::sha_cmd_t   cmd
);
    import sha_pkg::*;
    `include "sha256_message_hasher_defines.svh"

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_ADD, ST_PAD, ST_FILL, ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;
    logic       two_reg, two_next;
    logic [2:0] idx_reg, idx_next;
    logic       acc;

    assign s_ready      = (state_reg == ST_IDLE);
    assign acc          = s_valid && s_ready;
    assign m_valid      = (state_reg == ST_EMIT);
    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == 3'd7);

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        two_next   = two_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.byte_src = SRC_DATA;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    fin_next = s_end_of_message;
                    if (s_has_byte) begin
                        cmd.byte_we  = 1'b1;
                        cmd.fill_inc = 1'b1;
                        cmd.len_add  = 1'b1;
                        if (stat.fill == 6'd63) begin
                            state_next = ST_ROUND;
                            two_next   = 1'b0;
                            // pad byte still owed after this block
                            if (s_end_of_message) idx_next = 3'd3;
                        end else if (s_end_of_message) begin
                            state_next = ST_PAD;
                        end
                    end else if (s_end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (stat.round == 6'd0 && two_reg == 1'b0 && !cmd.round_en) begin
                    cmd.comp_start = 1'b1;
                    two_next = 1'b1;
                end else begin
                    cmd.round_en = 1'b1;
                    if (stat.round == 6'd63) state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.chain_add = 1'b1;
                two_next = 1'b0;
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (stat.fill == 6'd0 && idx_reg == 3'd1) begin
                    // finished the length block
                    state_next = ST_EMIT;
                    idx_next   = 3'd0;
                end else if (idx_reg == 3'd3) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_PAD: begin
                cmd.byte_we  = 1'b1;
                cmd.byte_src = SRC_PAD;
                cmd.fill_inc = 1'b1;
                // pad in the last slot before the length: the length follows directly
                if (stat.fill == LEN_POS - 6'd1) idx_next = 3'd2;
                else idx_next = 3'd0;
                // pad in the final byte: compress before the length block
                if (stat.fill == 6'd63) state_next = ST_ROUND;
                else state_next = ST_FILL;
            end
            ST_FILL: begin
                cmd.byte_we  = 1'b1;
                cmd.fill_inc = 1'b1;
                if (stat.fill >= LEN_POS && idx_reg == 3'd0 && stat.fill != 6'd0) begin
                    cmd.byte_src = SRC_ZERO;
                    if (stat.fill == 6'd63) state_next = ST_ROUND;
                end else if (stat.fill >= LEN_POS) begin
                    cmd.byte_src = SRC_LEN;
                    if (stat.fill == 6'd63) begin
                        state_next = ST_ROUND;
                        idx_next   = 3'd1;
                    end
                end else begin
                    cmd.byte_src = SRC_ZERO;
                    if (stat.fill == LEN_POS - 6'd1) idx_next = 3'd2;
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        state_next     = ST_IDLE;
                        cmd.chain_init = 1'b1;
                        cmd.len_clr    = 1'b1;
                        cmd.fill_clr   = 1'b1;
                        fin_next       = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            two_reg   <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            two_reg   <= two_next;
            idx_reg   <= idx_next;
        end
    end

    `SHA_ASSERT_IMP(a_out_idle, aclk, aresetn, m_valid, !s_ready)
    `SHA_ASSERT_NEXT(a_last_back, aclk, aresetn, m_valid && m_ready && m_last_word,
        state_reg == ST_IDLE)
    `SHA_ASSERT_IMP(a_round_busy, aclk, aresetn, state_reg == ST_ROUND, !m_valid && !s_ready)

endmodule
`default_nettype wire
